// ===== rtl/nvs_pkg.sv =====
// Shared types and constants for the NV12 to planar splitter.
`timescale 1ns / 1ps
`default_nettype none
package nvs_pkg;

  localparam int unsigned CFG_W    = 14;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PLANE_W  = 2;
  localparam int unsigned LUMA_W   = 26;
  localparam int unsigned CHROMA_W = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Result queue between classifier and output side.
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [PLANE_W-1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_STRIDE  = 2'd0,
    CFG_SLICE_HEIGHT = 2'd1,
    CFG_VIDEO_WIDTH  = 2'd2,
    CFG_VIDEO_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] line_stride;
    logic [CFG_W-1:0] slice_height;
    logic [CFG_W-1:0] video_width;
    logic [CFG_W-1:0] video_height;
  } cfg_t;

  typedef struct packed {
    plane_e              plane;
    logic [BYTE_W-1:0]   pixel_byte;
    logic [LUMA_W-1:0]   plane_index;
    logic                frame_last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/nvs_if.sv =====
// Valid/ready channel interfaces for input bytes and output words.
`timescale 1ns / 1ps
`default_nettype none
interface nvs_in_if;
  logic                      valid;
  logic                      ready;
  logic [nvs_pkg::BYTE_W-1:0] in_byte;
  logic                      frame_start;

  modport source (output valid, output in_byte, output frame_start, input ready);
  modport sink   (input valid, input in_byte, input frame_start, output ready);
endinterface

interface nvs_out_if;
  logic                        valid;
  logic                        ready;
  nvs_pkg::plane_e             plane;
  logic [nvs_pkg::BYTE_W-1:0]  pixel_byte;
  logic [nvs_pkg::LUMA_W-1:0]  plane_index;
  logic                        frame_last;

  modport source (output valid, output plane, output pixel_byte, output plane_index,
                  output frame_last, input ready);
  modport sink   (input valid, input plane, input pixel_byte, input plane_index,
                  input frame_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/nv12_to_planar_yuv_splitter.sv =====
// Top level of the NV12 to planar Y/U/V byte splitter.
`timescale 1ns / 1ps
`default_nettype none
// Takes an NV12 frame buffer one byte per word (frame_start on the first
// byte restarts all position counters) and emits only the visible bytes,
// each tagged with its plane (Y, U or V) and its index within that plane.
// Luma covers min(slice_height, video_height) stored lines; chroma begins
// at stored line slice_height and covers video_height/2 lines, U and V
// alternating, with U and V of a pair sharing one index. Kept width is
// min(video_width, line_stride); an odd kept width suppresses chroma.
// Registers saturate to 1 .. MAX_DIM. Stride padding, rows between the
// visible luma and the chroma area, and bytes past the chroma area are
// dropped. frame_last marks the final kept byte of a frame.
// Rate: one byte per clock sustained while the output accepts words. The
// classifier updates its column, row and index counters per accepted byte;
// a two-word result queue sits between it and the output, so input ready
// depends only on queue fill and a stalled output does not stop input until
// the queue is full. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_data_i, by the user only while the block is idle; nothing enforces it.
module nv12_to_planar_yuv_splitter #(
  parameter int unsigned MAX_DIM = 8192
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  nvs_in_if.sink                           in_i,
  nvs_out_if.source                        out_o,
  input  wire                              cfg_we_i,
  input  wire [nvs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [nvs_pkg::CFG_W-1:0]         cfg_data_i
);
  import nvs_pkg::*;

  cfg_t    cfg_q;
  logic    q_full;
  logic    push;
  result_t push_data;

  // register file, reset to a 1080p buffer with 16-line aligned slice
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_stride  <= CFG_W'(1920);
      cfg_q.slice_height <= CFG_W'(1088);
      cfg_q.video_width  <= CFG_W'(1920);
      cfg_q.video_height <= CFG_W'(1080);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LINE_STRIDE:  cfg_q.line_stride  <= cfg_data_i;
        CFG_SLICE_HEIGHT: cfg_q.slice_height <= cfg_data_i;
        CFG_VIDEO_WIDTH:  cfg_q.video_width  <= cfg_data_i;
        CFG_VIDEO_HEIGHT: cfg_q.video_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: counters and classification
  nvs_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_i.valid),
    .in_byte_i     (in_i.in_byte),
    .frame_start_i (in_i.frame_start),
    .in_ready_o    (in_i.ready),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // back: queue holding finished words for the output side
  nvs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

// ===== rtl/nvs_front.sv =====
// Front end: position counters and Y/U/V classification of each input byte.
`timescale 1ns / 1ps
`default_nettype none
module nvs_front #(
  parameter int unsigned MAX_DIM = 8192
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  nvs_pkg::cfg_t                 cfg_i,
  input  wire                           in_valid_i,
  input  wire [nvs_pkg::BYTE_W-1:0]     in_byte_i,
  input  wire                           frame_start_i,
  output logic                          in_ready_o,
  input  wire                           q_full_i,
  output logic                          push_o,
  output nvs_pkg::result_t              push_data_o
);
  import nvs_pkg::*;

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned ColW = $clog2(MAX_DIM);
  localparam int unsigned RowW = $clog2(MAX_DIM + MAX_DIM / 2 + 1);
  localparam int unsigned CmpW = (DimW > CFG_W) ? DimW : CFG_W;

  // saturate a register to 1 .. MAX_DIM
  function automatic logic [DimW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CmpW-1:0] ext;
    ext = CmpW'(v);
    if (ext == '0) begin
      clamp_dim = DimW'(1);
    end else if (ext > CmpW'(MAX_DIM)) begin
      clamp_dim = DimW'(MAX_DIM);
    end else begin
      clamp_dim = DimW'(ext);
    end
  endfunction

  logic [DimW-1:0]     stride, sh, vw, vh, cw, luma_rows, chroma_rows;
  logic [RowW-1:0]     end_row;
  logic                chroma_on;

  logic [ColW-1:0]     col_q, col_d, col_cur;
  logic [RowW-1:0]     row_q, row_d, row_cur;
  logic [LUMA_W-1:0]   luma_q, luma_d, luma_cur;
  logic [CHROMA_W-1:0] chroma_q, chroma_d, chroma_cur;

  logic                fire, active, in_col, is_luma, is_chroma, wrap, odd;
  logic [DimW-1:0]     col_inc;

  always_comb begin
    stride      = clamp_dim(cfg_i.line_stride);
    sh          = clamp_dim(cfg_i.slice_height);
    vw          = clamp_dim(cfg_i.video_width);
    vh          = clamp_dim(cfg_i.video_height);
    cw          = (vw < stride) ? vw : stride;
    luma_rows   = (sh < vh) ? sh : vh;
    chroma_rows = vh >> 1;
    end_row     = RowW'(sh) + RowW'(chroma_rows);
    chroma_on   = !cw[0] && (chroma_rows != '0);
  end

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  // frame_start restarts the counters before this byte is placed
  assign col_cur    = frame_start_i ? '0 : col_q;
  assign row_cur    = frame_start_i ? '0 : row_q;
  assign luma_cur   = frame_start_i ? '0 : luma_q;
  assign chroma_cur = frame_start_i ? '0 : chroma_q;

  always_comb begin
    active    = row_cur < end_row;
    in_col    = DimW'(col_cur) < cw;
    odd       = col_cur[0];
    is_luma   = active && in_col && (row_cur < RowW'(luma_rows));
    is_chroma = active && in_col && !is_luma && chroma_on && (row_cur >= RowW'(sh));
    col_inc   = DimW'(col_cur) + DimW'(1);
    wrap      = col_inc >= stride;

    col_d    = col_cur;
    row_d    = row_cur;
    luma_d   = luma_cur;
    chroma_d = chroma_cur;
    if (active) begin
      col_d = wrap ? '0 : ColW'(col_inc);
      row_d = wrap ? row_cur + RowW'(1) : row_cur;
    end
    if (is_luma) begin
      luma_d = luma_cur + LUMA_W'(1);
    end
    if (is_chroma && odd) begin
      chroma_d = chroma_cur + CHROMA_W'(1);
    end
  end

  always_comb begin
    push_o                  = fire && (is_luma || is_chroma);
    push_data_o.pixel_byte  = in_byte_i;
    if (is_luma) begin
      push_data_o.plane       = PLANE_Y;
      push_data_o.plane_index = luma_cur;
      push_data_o.frame_last  = !chroma_on
                                && (row_cur == RowW'(luma_rows - DimW'(1)))
                                && (col_cur == ColW'(cw - DimW'(1)));
    end else begin
      push_data_o.plane       = odd ? PLANE_V : PLANE_U;
      push_data_o.plane_index = LUMA_W'(chroma_cur);
      push_data_o.frame_last  = (row_cur == end_row - RowW'(1))
                                && (col_cur == ColW'(cw - DimW'(1)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      luma_q   <= '0;
      chroma_q <= '0;
    end else if (fire) begin
      col_q    <= col_d;
      row_q    <= row_d;
      luma_q   <= luma_d;
      chroma_q <= chroma_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/nvs_queue.sv =====
// Back end: short result queue whose head drives the output channel.
`timescale 1ns / 1ps
`default_nettype none
module nvs_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  nvs_pkg::result_t    push_data_i,
  output logic                full_o,
  nvs_out_if.source           out_o
);
  import nvs_pkg::*;

  result_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                pop;

  assign full_o = cnt_q == QCNT_W'(QDEPTH);
  assign pop    = out_o.valid && out_o.ready;

  assign out_o.valid       = cnt_q != '0;
  assign out_o.plane       = mem_q[rd_ptr_q].plane;
  assign out_o.pixel_byte  = mem_q[rd_ptr_q].pixel_byte;
  assign out_o.plane_index = mem_q[rd_ptr_q].plane_index;
  assign out_o.frame_last  = mem_q[rd_ptr_q].frame_last;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
    else $error("queue count did not follow push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == QCNT_W'(QDEPTH)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers inconsistent with count");
`endif

endmodule
`default_nettype wire
